// File: hw/rtl/dicl_pkg.sv
// ----------------------------------------------------------------------------
// dicl_pkg
// Shared types and constants of the display init command list parser.
// ----------------------------------------------------------------------------
package dicl_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ArgW   = 7;
  localparam int unsigned MsW    = 9;

  localparam logic [ByteW-1:0] DelayLongCode = 8'd255;
  localparam logic [MsW-1:0]   DelayLongMs   = 9'd500;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_CMD   = 3'd1,
    PH_ARGC  = 3'd2,
    PH_ARGS  = 3'd3,
    PH_DELAY = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic             has;
    kind_t            kind;
    logic [ByteW-1:0] value;
    logic [MsW-1:0]   ms;
    logic             done;
  } dicl_result_t;

endpackage

// File: hw/rtl/dicl_in_stage.sv
// ----------------------------------------------------------------------------
// dicl_in_stage
// Input register that holds one table byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dicl_in_stage
  import dicl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] list_byte,
  input  logic             take,
  output logic             held_valid,
  output logic [ByteW-1:0] held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= list_byte;
    end
  end

endmodule

// File: hw/rtl/dicl_parser.sv
// ----------------------------------------------------------------------------
// dicl_parser
// Parse state registers and the per-byte decode of the command table.
// ----------------------------------------------------------------------------
module dicl_parser
  import dicl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ByteW-1:0] cur_byte,
  output dicl_result_t     res
);

  phase_t           phase, phase_next;
  logic [ByteW-1:0] commands_left, commands_left_next;
  logic [ArgW-1:0]  args_left, args_left_next;
  logic             delay_pending, delay_pending_next;
  logic [ByteW-1:0] cmds_dec;
  logic [ArgW-1:0]  args_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      commands_left <= '0;
      args_left     <= '0;
      delay_pending <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      commands_left <= commands_left_next;
      args_left     <= args_left_next;
      delay_pending <= delay_pending_next;
    end
  end

  assign cmds_dec = commands_left - 8'd1;
  assign args_dec = args_left - 7'd1;

  always_comb begin
    phase_next         = phase;
    commands_left_next = commands_left;
    args_left_next     = args_left;
    delay_pending_next = delay_pending;
    res                = '{has: 1'b0, kind: KIND_CMD, value: '0, ms: '0, done: 1'b0};
    unique case (phase)
      PH_CMD: begin
        res.has    = 1'b1;
        res.kind   = KIND_CMD;
        res.value  = cur_byte;
        phase_next = PH_ARGC;
      end
      PH_ARGC: begin
        args_left_next     = cur_byte[ArgW-1:0];
        delay_pending_next = cur_byte[ByteW-1];
        if (cur_byte[ArgW-1:0] != '0) begin
          phase_next = PH_ARGS;
        end else if (cur_byte[ByteW-1]) begin
          phase_next = PH_DELAY;
        end else begin
          commands_left_next = cmds_dec;
          delay_pending_next = 1'b0;
          args_left_next     = '0;
          if (cmds_dec == '0) begin
            phase_next = PH_COUNT;
            res.has    = 1'b1;
            res.kind   = KIND_DONE;
            res.done   = 1'b1;
          end else begin
            phase_next = PH_CMD;
          end
        end
      end
      PH_ARGS: begin
        args_left_next = args_dec;
        res.has        = 1'b1;
        res.kind       = KIND_DATA;
        res.value      = cur_byte;
        if (args_dec == '0) begin
          if (delay_pending) begin
            phase_next = PH_DELAY;
          end else begin
            commands_left_next = cmds_dec;
            delay_pending_next = 1'b0;
            if (cmds_dec == '0) begin
              phase_next = PH_COUNT;
              res.done   = 1'b1;
            end else begin
              phase_next = PH_CMD;
            end
          end
        end
      end
      PH_DELAY: begin
        commands_left_next = cmds_dec;
        delay_pending_next = 1'b0;
        args_left_next     = '0;
        res.has            = 1'b1;
        res.kind           = KIND_DELAY;
        res.ms             = (cur_byte == DelayLongCode) ? DelayLongMs : {1'b0, cur_byte};
        if (cmds_dec == '0) begin
          phase_next = PH_COUNT;
          res.done   = 1'b1;
        end else begin
          phase_next = PH_CMD;
        end
      end
      default: begin
        args_left_next     = '0;
        delay_pending_next = 1'b0;
        commands_left_next = cur_byte;
        if (cur_byte == '0) begin
          phase_next = PH_COUNT;
          res.has    = 1'b1;
          res.kind   = KIND_DONE;
          res.done   = 1'b1;
        end else begin
          phase_next = PH_CMD;
        end
      end
    endcase
  end

endmodule

// File: hw/rtl/dicl_out_stage.sv
// ----------------------------------------------------------------------------
// dicl_out_stage
// Result register that holds one result item until it is taken.
// ----------------------------------------------------------------------------
module dicl_out_stage
  import dicl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dicl_result_t     res,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [ByteW-1:0] out_value,
  output logic [MsW-1:0]   delay_ms,
  output logic             list_done
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      out_kind  <= res.kind;
      out_value <= res.value;
      delay_ms  <= res.ms;
      list_done <= res.done;
    end
  end

endmodule

// File: hw/rtl/display_init_command_list_parser.sv
// ----------------------------------------------------------------------------
// display_init_command_list_parser
// Interprets a display init command table byte by byte and emits command,
// argument data, delay and end-of-list result items.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    list_byte
//   out      output     out_valid / out_ready  out_kind, out_value, delay_ms,
//                                              list_done
//
// One byte is accepted per cycle unless its result waits on a stalled out; it is
// held in the input register, then its result is loaded into the result register.
// Throughput is limited only by the result register draining on the out side.
// Reset clears the parse state to expecting a command count and empties both
// registers. A stall on out holds the result and backs up into the input
// register; bytes that give no result still pass while out is stalled.
// ----------------------------------------------------------------------------
module display_init_command_list_parser
  import dicl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] list_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [ByteW-1:0] out_value,
  output logic [MsW-1:0]   delay_ms,
  output logic             list_done
);

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             take;
  logic             room;
  dicl_result_t     res;

  assign take = held_valid && (!res.has || room);

  dicl_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .list_byte (list_byte),
    .take      (take),
    .held_valid(held_valid),
    .held_byte (held_byte)
  );

  dicl_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (take),
    .cur_byte(held_byte),
    .res     (res)
  );

  dicl_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && res.has),
    .res      (res),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind (out_kind),
    .out_value(out_value),
    .delay_ms (delay_ms),
    .list_done(list_done)
  );

`ifndef SYNTH
  a_cmd_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_CMD |-> !list_done)
    else $error("command result marked as end of list");

  a_ms_only_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DELAY |-> delay_ms == '0)
    else $error("nonzero delay on a non-delay result");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_DELAY || out_kind == KIND_DONE) |-> out_value == '0)
    else $error("value on a delay or done result");

  a_empty_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");
`endif

endmodule
